// File: rtl/ddpi_pkg.sv
// Shared types, constants and helpers for the differential drive PI controller.
// No dependencies; imported by ddpi_wheel_pi and the top level.
package ddpi_pkg;

  // Default number of fraction bits of the gain and integrator format
  localparam int unsigned FracBitsDef = 24;

  // Field and register widths
  localparam int unsigned CmdW   = 8;
  localparam int unsigned IrW    = 12;
  localparam int unsigned UsW    = 10;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned DutyW  = 16;
  localparam int unsigned GainW  = 24;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  // Error is setpoint minus speed, one bit wider than either
  localparam int unsigned ErrW   = SpeedW + 1;
  localparam int unsigned ProdW  = ErrW + GainW + 1;
  localparam int unsigned IntegW = 48;
  localparam int unsigned SumW   = IntegW + 1;
  // Working width for saturation to 16 bits
  localparam int unsigned SatW   = SumW + 1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegPropGain  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegIntegGain = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDutyOfs   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegIrStop    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegUsStop    = 3'd4;

  // Register reset values
  localparam logic [GainW-1:0]  PropGainRst  = 24'd167772;
  localparam logic [GainW-1:0]  IntegGainRst = 24'd27060;
  localparam logic [DutyW-1:0]  DutyOfsRst   = 16'd1100;
  localparam logic [IrW-1:0]    IrStopRst    = 12'd2000;
  localparam logic [UsW-1:0]    UsStopRst    = 10'd20;

  // Command bytes (ASCII digits)
  localparam logic [CmdW-1:0] CmdFwd   = 8'h31;
  localparam logic [CmdW-1:0] CmdRev   = 8'h32;
  localparam logic [CmdW-1:0] CmdLeft  = 8'h33;
  localparam logic [CmdW-1:0] CmdRight = 8'h34;
  localparam logic [CmdW-1:0] CmdStop  = 8'h35;
  localparam logic [CmdW-1:0] CmdInc   = 8'h36;
  localparam logic [CmdW-1:0] CmdDec   = 8'h37;

  // Setpoint constants
  localparam logic signed [SpeedW-1:0] SpFull   = 16'sd1000;
  localparam logic signed [SpeedW-1:0] SpHalf   = 16'sd500;
  localparam logic signed [SpeedW-1:0] SpRst    = -16'sd300;

  // Gains and offset handed to each wheel loop
  typedef struct packed {
    logic [GainW-1:0]        prop_gain;
    logic [GainW-1:0]        integ_gain;
    logic signed [DutyW-1:0] duty_offset;
  } pi_cfg_t;

  // Clamp a wide signed value to the 16-bit signed range
  function automatic logic signed [DutyW-1:0] sat16(input logic signed [SatW-1:0] v);
    logic signed [SatW-1:0] hi;
    logic signed [SatW-1:0] lo;
    hi = SatW'(32767);
    lo = -SatW'(32768);
    if (v > hi) begin
      return 16'sh7FFF;
    end else if (v < lo) begin
      return 16'sh8000;
    end else begin
      return v[DutyW-1:0];
    end
  endfunction

endpackage

// File: rtl/ddpi_wheel_pi.sv
// One wheel PI loop: error, saturating integrator, floored duty with offset.
// Depends on ddpi_pkg; instantiated twice by the top level.
module ddpi_wheel_pi import ddpi_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     advance_i,
  input  pi_cfg_t                  cfg_i,
  input  logic signed [SpeedW-1:0] setpoint_i,
  input  logic signed [SpeedW-1:0] speed_i,
  output logic signed [DutyW-1:0]  duty_o
);

  logic signed [IntegW-1:0] integ_q, integ_d;
  logic signed [ErrW-1:0]   err;
  logic signed [ProdW-1:0]  prop_prod, integ_prod;
  logic signed [SumW-1:0]   acc;
  logic signed [SumW-1:0]   sum;
  logic signed [SumW-1:0]   sum_shr;
  logic signed [SatW-1:0]   duty_wide;

  // Error in one extra bit
  assign err = {setpoint_i[SpeedW-1], setpoint_i} - {speed_i[SpeedW-1], speed_i};

  // Gains are unsigned: prepend a zero sign bit
  assign prop_prod  = $signed({1'b0, cfg_i.prop_gain})  * err;
  assign integ_prod = $signed({1'b0, cfg_i.integ_gain}) * err;

  // Accumulate and clamp the integrator
  assign acc = {integ_q[IntegW-1], integ_q}
             + {{(SumW-ProdW){integ_prod[ProdW-1]}}, integ_prod};

  always_comb begin
    if (acc[SumW-1] != acc[SumW-2]) begin
      integ_d = acc[SumW-1] ? {1'b1, {(IntegW-1){1'b0}}} : {1'b0, {(IntegW-1){1'b1}}};
    end else begin
      integ_d = acc[IntegW-1:0];
    end
  end

  // Proportional term plus new integrator, floored by arithmetic shift
  assign sum = {{(SumW-ProdW){prop_prod[ProdW-1]}}, prop_prod}
             + {integ_d[IntegW-1], integ_d};
  assign sum_shr = sum >>> FracBits;

  assign duty_wide = {sum_shr[SumW-1], sum_shr}
                   + {{(SatW-DutyW){cfg_i.duty_offset[DutyW-1]}}, cfg_i.duty_offset};
  assign duty_o = sat16(duty_wide);

  // Commit the integrator once per processed beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (advance_i) begin
      integ_q <= integ_d;
    end
  end

endmodule

// File: rtl/differential_drive_pi_controller_unit.sv
// Top level of the differential drive PI speed controller.
// Depends on ddpi_pkg and ddpi_wheel_pi (one instance per wheel).
//
// Takes one control period per beat and returns one result beat for each. A new
// beat is accepted every clock cycle unless both registers are full and the output
// is not taken; it enters the input register on acceptance, then the result register,
// where it waits until taken. The rate is set by the setpoint and integrator
// updates, whose feedback paths are combinational through the command decode, the
// 24x17 gain multipliers and the saturating integrator add. Configuration writes
// take effect on the next cycle and are meant to be issued while no beat is in flight.
// Duty values are floor((kp*err + integ) / 2^FRAC_BITS) + offset, clamped to 16
// bits signed; a front infrared level at or above its limit or a rear distance at
// or below its limit zeroes both setpoints.
module differential_drive_pi_controller_unit import ddpi_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write port
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgDataW-1:0]      cfg_wdata_i,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [CmdW-1:0]          command_i,
  input  logic [IrW-1:0]           ir_left_i,
  input  logic [IrW-1:0]           ir_right_i,
  input  logic [UsW-1:0]           us_back_left_i,
  input  logic [UsW-1:0]           us_back_right_i,
  input  logic signed [SpeedW-1:0] speed_left_i,
  input  logic signed [SpeedW-1:0] speed_right_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DutyW-1:0]  duty_left_o,
  output logic signed [DutyW-1:0]  duty_right_o,
  output logic signed [SpeedW-1:0] target_left_o,
  output logic signed [SpeedW-1:0] target_right_o,
  output logic                     obstacle_stop_o
);

  // Configuration registers
  pi_cfg_t        pi_cfg_q;
  logic [IrW-1:0] ir_stop_q;
  logic [UsW-1:0] us_stop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pi_cfg_q.prop_gain   <= PropGainRst;
      pi_cfg_q.integ_gain  <= IntegGainRst;
      pi_cfg_q.duty_offset <= DutyOfsRst;
      ir_stop_q            <= IrStopRst;
      us_stop_q            <= UsStopRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegPropGain:  pi_cfg_q.prop_gain   <= cfg_wdata_i;
        RegIntegGain: pi_cfg_q.integ_gain  <= cfg_wdata_i;
        RegDutyOfs:   pi_cfg_q.duty_offset <= cfg_wdata_i[DutyW-1:0];
        RegIrStop:    ir_stop_q            <= cfg_wdata_i[IrW-1:0];
        RegUsStop:    us_stop_q            <= cfg_wdata_i[UsW-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic                     in_valid_q;
  logic [CmdW-1:0]          command_q;
  logic [IrW-1:0]           ir_left_q, ir_right_q;
  logic [UsW-1:0]           us_left_q, us_right_q;
  logic signed [SpeedW-1:0] speed_left_q, speed_right_q;
  logic                     out_valid_q;
  logic                     advance;

  // Move a beat into the result register when it is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      command_q     <= command_i;
      ir_left_q     <= ir_left_i;
      ir_right_q    <= ir_right_i;
      us_left_q     <= us_back_left_i;
      us_right_q    <= us_back_right_i;
      speed_left_q  <= speed_left_i;
      speed_right_q <= speed_right_i;
    end
  end

  // Setpoint update from the command byte, then the obstacle interlock
  logic signed [SpeedW-1:0] sp_left_q, sp_right_q;
  logic signed [SpeedW-1:0] sp_left_cmd, sp_right_cmd;
  logic signed [SpeedW-1:0] sp_left_d, sp_right_d;
  logic                     stop;

  function automatic logic signed [SpeedW-1:0] step_sp(
    input logic signed [SpeedW-1:0] sp,
    input logic signed [SpeedW-1:0] delta
  );
    logic signed [SpeedW:0] s;
    s = {sp[SpeedW-1], sp} + {delta[SpeedW-1], delta};
    return sat16({{(SatW-SpeedW-1){s[SpeedW]}}, s});
  endfunction

  always_comb begin
    sp_left_cmd  = sp_left_q;
    sp_right_cmd = sp_right_q;
    unique case (command_q)
      CmdFwd: begin
        sp_left_cmd  = SpFull;
        sp_right_cmd = SpFull;
      end
      CmdRev: begin
        sp_left_cmd  = -SpFull;
        sp_right_cmd = -SpFull;
      end
      CmdLeft: begin
        sp_left_cmd  = -SpHalf;
        sp_right_cmd = SpHalf;
      end
      CmdRight: begin
        sp_left_cmd  = SpHalf;
        sp_right_cmd = -SpHalf;
      end
      CmdStop: begin
        sp_left_cmd  = '0;
        sp_right_cmd = '0;
      end
      CmdInc: begin
        sp_left_cmd  = step_sp(sp_left_q, SpHalf);
        sp_right_cmd = step_sp(sp_right_q, SpHalf);
      end
      CmdDec: begin
        sp_left_cmd  = step_sp(sp_left_q, -SpHalf);
        sp_right_cmd = step_sp(sp_right_q, -SpHalf);
      end
      default: ;
    endcase
  end

  assign stop = (ir_left_q >= ir_stop_q) || (ir_right_q >= ir_stop_q) ||
                (us_left_q <= us_stop_q) || (us_right_q <= us_stop_q);

  assign sp_left_d  = stop ? '0 : sp_left_cmd;
  assign sp_right_d = stop ? '0 : sp_right_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_left_q  <= SpRst;
      sp_right_q <= SpRst;
    end else if (advance) begin
      sp_left_q  <= sp_left_d;
      sp_right_q <= sp_right_d;
    end
  end

  // Wheel loops
  logic signed [DutyW-1:0] duty_left, duty_right;

  ddpi_wheel_pi #(.FracBits(FRAC_BITS)) u_pi_left (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .cfg_i      (pi_cfg_q),
    .setpoint_i (sp_left_d),
    .speed_i    (speed_left_q),
    .duty_o     (duty_left)
  );

  ddpi_wheel_pi #(.FracBits(FRAC_BITS)) u_pi_right (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .cfg_i      (pi_cfg_q),
    .setpoint_i (sp_right_d),
    .speed_i    (speed_right_q),
    .duty_o     (duty_right)
  );

  // Result register
  logic signed [DutyW-1:0]  duty_left_q, duty_right_q;
  logic signed [SpeedW-1:0] target_left_q, target_right_q;
  logic                     stop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      duty_left_q    <= duty_left;
      duty_right_q   <= duty_right;
      target_left_q  <= sp_left_d;
      target_right_q <= sp_right_d;
      stop_q         <= stop;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign duty_left_o     = duty_left_q;
  assign duty_right_o    = duty_right_q;
  assign target_left_o   = target_left_q;
  assign target_right_o  = target_right_q;
  assign obstacle_stop_o = stop_q;

  // Checks
  a_stop_zero_targets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && obstacle_stop_o |-> target_left_o == '0 && target_right_o == '0)
    else $error("obstacle stop with nonzero target");

  a_accept_fills_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> in_valid_q)
    else $error("accepted beat not held in input register");

  a_advance_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("processed beat missing from result register");

  a_setpoint_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(sp_left_q) && $stable(sp_right_q))
    else $error("setpoint changed without a processed beat");

endmodule

// File: bench/differential_drive_pi_controller_unit_test.sv
`timescale 1ns / 100ps
// Self-checking bench for differential_drive_pi_controller_unit: sends control periods,
// predicts setpoints, interlock and duties in a local model and checks every result beat.
// Depends on ddpi_pkg and the RTL of the controller.
module differential_drive_pi_controller_unit_test;
  import ddpi_pkg::*;

  localparam longint IntegHi = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint IntegLo = -IntegHi - 1;
  localparam longint DutyHi  = 32767;
  localparam longint DutyLo  = -32768;
  localparam int unsigned DrainCycles = 6;

  localparam logic [CfgDataW-1:0] GainMax    = '1;
  localparam logic [IrW-1:0]      IrTop      = '1;
  localparam logic [UsW-1:0]      UsTop      = '1;
  localparam logic [SpeedW-1:0]   SpeedTop   = 16'h7FFF;
  localparam logic [SpeedW-1:0]   SpeedBottom = 16'h8000;

  // Command bytes that the controller must ignore
  localparam logic [CmdW-1:0] CmdNone     = 8'h00;
  localparam logic [CmdW-1:0] CmdDigit0   = 8'h30;
  localparam logic [CmdW-1:0] CmdDigit8   = 8'h38;
  localparam logic [CmdW-1:0] CmdAllOnes  = 8'hFF;

  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic [IrW-1:0]    ir_left;
    logic [IrW-1:0]    ir_right;
    logic [UsW-1:0]    us_back_left;
    logic [UsW-1:0]    us_back_right;
    logic [SpeedW-1:0] speed_left;
    logic [SpeedW-1:0] speed_right;
  } period_t;

  typedef struct packed {
    logic [DutyW-1:0]  duty_left;
    logic [DutyW-1:0]  duty_right;
    logic [SpeedW-1:0] target_left;
    logic [SpeedW-1:0] target_right;
    logic              obstacle_stop;
  } drive_t;

  typedef enum int unsigned {StallNone, StallRandom, StallLong, StallToggle} stall_mode_e;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]       cfg_index_i = '0;
  logic [CfgDataW-1:0]      cfg_wdata_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [CmdW-1:0]          command_i = '0;
  logic [IrW-1:0]           ir_left_i = '0;
  logic [IrW-1:0]           ir_right_i = '0;
  logic [UsW-1:0]           us_back_left_i = '0;
  logic [UsW-1:0]           us_back_right_i = '0;
  logic signed [SpeedW-1:0] speed_left_i = '0;
  logic signed [SpeedW-1:0] speed_right_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b1;
  logic signed [DutyW-1:0]  duty_left_o;
  logic signed [DutyW-1:0]  duty_right_o;
  logic signed [SpeedW-1:0] target_left_o;
  logic signed [SpeedW-1:0] target_right_o;
  logic                     obstacle_stop_o;

  // Model copy of the registers and the loop state
  logic [GainW-1:0]         kp_q = PropGainRst;
  logic [GainW-1:0]         ki_q = IntegGainRst;
  logic signed [DutyW-1:0]  offset_q = DutyOfsRst;
  logic [IrW-1:0]           ir_limit_q = IrStopRst;
  logic [UsW-1:0]           us_limit_q = UsStopRst;
  logic signed [SpeedW-1:0] target_l_q = SpRst;
  logic signed [SpeedW-1:0] target_r_q = SpRst;
  logic signed [IntegW-1:0] integ_l_q = '0;
  logic signed [IntegW-1:0] integ_r_q = '0;

  drive_t      pending_drives[$];
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  stall_mode_e stall_mode = StallNone;
  int unsigned mode_left = 0;

  differential_drive_pi_controller_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .ir_left_i      (ir_left_i),
    .ir_right_i     (ir_right_i),
    .us_back_left_i (us_back_left_i),
    .us_back_right_i(us_back_right_i),
    .speed_left_i   (speed_left_i),
    .speed_right_i  (speed_right_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .duty_left_o    (duty_left_o),
    .duty_right_o   (duty_right_o),
    .target_left_o  (target_left_o),
    .target_right_o (target_right_o),
    .obstacle_stop_o(obstacle_stop_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Clamp to the 16-bit signed range
  function automatic logic [DutyW-1:0] clamp_word(input longint v);
    if (v > DutyHi) return 16'h7FFF;
    if (v < DutyLo) return 16'h8000;
    return v[DutyW-1:0];
  endfunction

  function automatic bit chance(input int unsigned pct);
    return $urandom_range(1, 100) <= pct;
  endfunction

  // One wheel: error, saturating integrator, floored PI sum plus offset
  task automatic advance_wheel(input logic signed [SpeedW-1:0] target,
                               input logic signed [SpeedW-1:0] speed,
                               inout logic signed [IntegW-1:0] integ,
                               output logic [DutyW-1:0] duty);
    longint err;
    longint acc;
    longint pi_sum;
    err = longint'(target) - longint'(speed);
    acc = longint'(integ) + longint'(ki_q) * err;
    if (acc > IntegHi) acc = IntegHi;
    else if (acc < IntegLo) acc = IntegLo;
    integ = acc[IntegW-1:0];
    pi_sum = (longint'(kp_q) * err + acc) >>> FracBitsDef;
    duty = clamp_word(pi_sum + longint'(offset_q));
  endtask

  // Advance the model by one accepted period and queue the drive it yields
  task automatic predict_drive(input period_t p);
    drive_t           r;
    logic             stop;
    logic [DutyW-1:0] dl;
    logic [DutyW-1:0] dr;
    case (p.command)
      CmdFwd: begin
        target_l_q = SpFull;
        target_r_q = SpFull;
      end
      CmdRev: begin
        target_l_q = -SpFull;
        target_r_q = -SpFull;
      end
      CmdLeft: begin
        target_l_q = -SpHalf;
        target_r_q = SpHalf;
      end
      CmdRight: begin
        target_l_q = SpHalf;
        target_r_q = -SpHalf;
      end
      CmdStop: begin
        target_l_q = '0;
        target_r_q = '0;
      end
      CmdInc: begin
        target_l_q = clamp_word(longint'(target_l_q) + longint'(SpHalf));
        target_r_q = clamp_word(longint'(target_r_q) + longint'(SpHalf));
      end
      CmdDec: begin
        target_l_q = clamp_word(longint'(target_l_q) - longint'(SpHalf));
        target_r_q = clamp_word(longint'(target_r_q) - longint'(SpHalf));
      end
      default: ;
    endcase
    stop = (p.ir_left >= ir_limit_q) || (p.ir_right >= ir_limit_q) ||
           (p.us_back_left <= us_limit_q) || (p.us_back_right <= us_limit_q);
    if (stop) begin
      target_l_q = '0;
      target_r_q = '0;
    end
    advance_wheel(target_l_q, p.speed_left, integ_l_q, dl);
    advance_wheel(target_r_q, p.speed_right, integ_r_q, dr);
    r.duty_left     = dl;
    r.duty_right    = dr;
    r.target_left   = target_l_q;
    r.target_right  = target_r_q;
    r.obstacle_stop = stop;
    pending_drives.push_back(r);
  endtask

  // Drive one beat, hold it until accepted, then keep the burst going or idle a while
  task automatic send_period(input period_t p);
    in_valid_i      <= 1'b1;
    command_i       <= p.command;
    ir_left_i       <= p.ir_left;
    ir_right_i      <= p.ir_right;
    us_back_left_i  <= p.us_back_left;
    us_back_right_i <= p.us_back_right;
    speed_left_i    <= p.speed_left;
    speed_right_i   <= p.speed_right;
    do @(posedge clk_i); while (!in_ready_o);
    predict_drive(p);
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = chance(15) ? $urandom_range(30, 90) : $urandom_range(0, 10);
    end
  endtask

  // Stop sending and wait until every expected beat has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_drives.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (index)
      RegPropGain:  kp_q = data[GainW-1:0];
      RegIntegGain: ki_q = data[GainW-1:0];
      RegDutyOfs:   offset_q = data[DutyW-1:0];
      RegIrStop:    ir_limit_q = data[IrW-1:0];
      RegUsStop:    us_limit_q = data[UsW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [CfgDataW-1:0] kp, input logic [CfgDataW-1:0] ki,
                            input logic [CfgDataW-1:0] ofs, input logic [CfgDataW-1:0] ir,
                            input logic [CfgDataW-1:0] us);
    wait_drained();
    write_reg(RegPropGain, kp);
    write_reg(RegIntegGain, ki);
    write_reg(RegDutyOfs, ofs);
    write_reg(RegIrStop, ir);
    write_reg(RegUsStop, us);
  endtask

  // Clear sensors, zero speed
  function automatic period_t quiet_period(input logic [CmdW-1:0] command);
    period_t p;
    p               = '0;
    p.command       = command;
    p.us_back_left  = UsTop;
    p.us_back_right = UsTop;
    return p;
  endfunction

  // Mostly valid commands and clear sensors; each sensor trips on its own now and then
  function automatic period_t random_period(input int unsigned clear_pct);
    period_t p;
    p.command = chance(75) ? CmdFwd + CmdW'($urandom_range(0, CmdDec - CmdFwd))
                           : CmdW'($urandom_range(0, 255));
    p.ir_left = (chance(clear_pct) && ir_limit_q != 0)
              ? IrW'($urandom_range(0, ir_limit_q - 1)) : IrW'($urandom);
    p.ir_right = (chance(clear_pct) && ir_limit_q != 0)
               ? IrW'($urandom_range(0, ir_limit_q - 1)) : IrW'($urandom);
    p.us_back_left = (chance(clear_pct) && us_limit_q != UsTop)
                   ? UsW'($urandom_range(us_limit_q + 1, UsTop)) : UsW'($urandom);
    p.us_back_right = (chance(clear_pct) && us_limit_q != UsTop)
                    ? UsW'($urandom_range(us_limit_q + 1, UsTop)) : UsW'($urandom);
    p.speed_left  = chance(60) ? SpeedW'($urandom) : SpeedW'($urandom_range(0, 4000) - 2000);
    p.speed_right = chance(60) ? SpeedW'($urandom) : SpeedW'($urandom_range(0, 4000) - 2000);
    return p;
  endfunction

  // Receiver stalls: switch between patterns at random
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(StallNone, StallToggle));
      mode_left  = $urandom_range(20, 120);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      StallNone:   out_ready_i <= 1'b1;
      StallRandom: out_ready_i <= chance(70);
      StallLong:   out_ready_i <= chance(12) ? ~out_ready_i : out_ready_i;
      default:     out_ready_i <= ~out_ready_i;
    endcase
  end

  task automatic compare_field(input string name, input logic [DutyW-1:0] want,
                               input logic [DutyW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  // Check each result beat against the oldest expected drive
  always @(posedge clk_i) begin : check_drive
    drive_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_drives.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        mismatches++;
      end else begin
        want = pending_drives.pop_front();
        compare_field("duty_left", want.duty_left, duty_left_o);
        compare_field("duty_right", want.duty_right, duty_right_o);
        compare_field("target_left", want.target_left, target_left_o);
        compare_field("target_right", want.target_right, target_right_o);
        compare_field("obstacle_stop", DutyW'(want.obstacle_stop), DutyW'(obstacle_stop_o));
      end
    end
  end

  // Setpoints start at the reset value; unknown bytes keep them
  task automatic test_reset_state();
    period_t p;
    send_period(quiet_period(CmdNone));
    p = quiet_period(CmdAllOnes);
    p.speed_left  = SpeedTop;
    p.speed_right = SpeedBottom;
    send_period(p);
  endtask

  task automatic test_each_command();
    period_t p;
    for (int c = CmdFwd; c <= CmdDec; c++) begin
      p = quiet_period(CmdW'(c));
      p.speed_left  = SpeedW'($urandom_range(0, 2000) - 1000);
      p.speed_right = SpeedW'($urandom_range(0, 2000) - 1000);
      send_period(p);
    end
    send_period(quiet_period(CmdDigit0));
    send_period(quiet_period(CmdDigit8));
    send_period(quiet_period(CmdInc));
  endtask

  // Interlock on each sensor tripping alone, then at and just clear of each limit
  task automatic test_sensor_extremes();
    period_t p;
    p = quiet_period(CmdFwd);
    p.ir_left = IrTop;
    send_period(p);
    p = quiet_period(CmdRev);
    p.ir_right = IrTop;
    p.speed_left = SpeedBottom;
    send_period(p);
    p = quiet_period(CmdLeft);
    p.us_back_left = '0;
    p.speed_right = SpeedTop;
    send_period(p);
    p = quiet_period(CmdRight);
    p.us_back_right = '0;
    send_period(p);
    p = quiet_period(CmdFwd);
    p.ir_left  = ir_limit_q - IrW'(1);
    p.ir_right = ir_limit_q - IrW'(1);
    send_period(p);
    p = quiet_period(CmdFwd);
    p.ir_left = ir_limit_q;
    send_period(p);
    p = quiet_period(CmdRev);
    p.us_back_left = us_limit_q;
    send_period(p);
    p = quiet_period(CmdRev);
    p.us_back_left  = us_limit_q + UsW'(1);
    p.us_back_right = us_limit_q + UsW'(1);
    p.speed_left    = SpeedBottom;
    p.speed_right   = SpeedBottom;
    send_period(p);
    p = quiet_period(CmdFwd);
    p.speed_left  = SpeedTop;
    p.speed_right = SpeedTop;
    send_period(p);
  endtask

  // Random periods at reset gains, with a full drain now and then
  task automatic test_random_periods(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_period(random_period(85));
      if (i % 137 == 136) wait_drained();
    end
  endtask

  // Ramp the setpoints into both ends of their range, then random step runs
  task automatic test_setpoint_limits();
    period_t     p;
    logic [CmdW-1:0] cmd;
    int unsigned run;
    for (int i = 0; i < 80; i++) begin
      p = random_period(100);
      p.command = CmdInc;
      send_period(p);
    end
    for (int i = 0; i < 150; i++) begin
      p = random_period(100);
      p.command = CmdDec;
      send_period(p);
    end
    for (int i = 0; i < 100; i += run) begin
      cmd = chance(50) ? CmdInc : CmdDec;
      run = $urandom_range(5, 40);
      for (int unsigned k = 0; k < run; k++) begin
        p = random_period(97);
        if (chance(90)) p.command = cmd;
        send_period(p);
      end
    end
  endtask

  // Drive both integrators into saturation with opposite signs, then back off
  task automatic test_integrator_limits();
    period_t p;
    set_config(PropGainRst, GainMax, DutyOfsRst, IrStopRst, UsStopRst);
    for (int i = 0; i < 400; i++) begin
      p = random_period(100);
      p.command = (i == 0) ? CmdFwd : CmdNone;
      if (i < 320) begin
        p.speed_left  = SpeedBottom + SpeedW'($urandom_range(0, 200));
        p.speed_right = SpeedTop - SpeedW'($urandom_range(0, 200));
      end else begin
        p.speed_left  = SpeedTop - SpeedW'($urandom_range(0, 200));
        p.speed_right = SpeedBottom + SpeedW'($urandom_range(0, 200));
      end
      send_period(p);
    end
  endtask

  // Register extremes, ignored indexes and random settings
  task automatic test_register_settings();
    repeat (70) begin
      set_config('0, '0, 24'h5A8000, IrTop, '0);
      break;
    end
    repeat (70) send_period(random_period(80));
    set_config(GainMax, GainMax, 24'h007FFF, '0, UsTop);
    repeat (60) send_period(random_period(80));
    wait_drained();
    for (int i = RegUsStop + 1; i < (1 << CfgIdxW); i++) begin
      write_reg(CfgIdxW'(i), CfgDataW'($urandom));
    end
    repeat (30) send_period(random_period(80));
    repeat (3) begin
      set_config(CfgDataW'($urandom_range(0, GainMax) >> $urandom_range(0, 14)),
                 CfgDataW'($urandom_range(0, GainMax) >> $urandom_range(4, 20)),
                 CfgDataW'($urandom), CfgDataW'($urandom), CfgDataW'($urandom));
      repeat (70) send_period(random_period(85));
    end
    set_config(PropGainRst, IntegGainRst, DutyOfsRst, IrStopRst, UsStopRst);
    repeat (30) send_period(random_period(85));
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_state();
    test_each_command();
    test_sensor_extremes();
    test_random_periods(500);
    test_setpoint_limits();
    test_integrator_limits();
    test_register_settings();
    wait_drained();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ddpi_pkg.sv
rtl/ddpi_wheel_pi.sv
rtl/differential_drive_pi_controller_unit.sv
bench/differential_drive_pi_controller_unit_test.sv
